/* hdl/smpq_pkg.sv */
// smpq_pkg: shared constants and types for the sorted max priority queue.
// Used by smpq_cell, sorted_max_priority_queue and the bench; depends on nothing.
package smpq_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } cell_ctl_t;

endpackage

/* hdl/smpq_cell.sv */
// smpq_cell: one slot of the sorted shift-register queue.
// Holds one key and its valid bit; depends on smpq_pkg.
module smpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  smpq_pkg::cell_ctl_t ctl,
  input  logic               prev_take,
  input  logic               prev_valid,
  input  smpq_pkg::key_t     prev_key,
  input  logic               next_valid,
  input  smpq_pkg::key_t     next_key,
  output logic               take,
  output logic               valid,
  output smpq_pkg::key_t     key
);
  import smpq_pkg::*;

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;

  // new key belongs at or above this slot
  assign take  = !valid_r || (ctl.key > key_r);
  assign valid = valid_r;
  assign key   = key_r;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctl.push) begin
      valid_nxt = valid_r | prev_valid;
      if (take && prev_take) begin
        key_nxt = prev_key;
      end else if (take) begin
        key_nxt = ctl.key;
      end
    end else if (ctl.pop) begin
      valid_nxt = next_valid;
      key_nxt   = next_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

/* hdl/sorted_max_priority_queue.sv */
// sorted_max_priority_queue: max-first priority queue over a row of smpq_cell slots.
// Depends on smpq_pkg and smpq_cell.
// The result strobe is registered: it rises in the cycle after the start beat.
// Throughput: one beat per cycle; every cell compares with the broadcast key and
// shifts in the same cycle. busy stays low. Reset (synchronous, rst_n low) empties
// the queue and clears the strobe.
module sorted_max_priority_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic signed [31:0]           in_key_in,
  output logic                         out_strobe,
  output logic                         out_popped_valid,
  output logic signed [31:0]           out_key_out,
  output logic                         out_was_empty,
  output logic                         out_dropped,
  output logic [smpq_pkg::CNT_W-1:0]   out_occupancy
);
  import smpq_pkg::*;

  cell_ctl_t ctl;
  logic      take_w  [DEPTH];
  logic      valid_w [DEPTH];
  key_t      key_w   [DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full;
  logic             strobe_r;
  logic             popped_valid_r, was_empty_r, dropped_r;
  key_t             key_out_r;
  logic [CNT_W-1:0] occ_r;

  assign busy = 1'b0;
  assign full = (count_r == CNT_W'(DEPTH));

  always_comb begin
    ctl.push = start && (in_action == ACT_PUSH);
    ctl.pop  = start && (in_action == ACT_POP);
    ctl.key  = in_key_in;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic prev_take, prev_valid, next_valid;
      key_t prev_key, next_key;
      if (gi == 0) begin : g_head
        assign prev_take  = 1'b0;
        assign prev_valid = 1'b1;
        assign prev_key   = '0;
      end else begin : g_body
        assign prev_take  = take_w[gi-1];
        assign prev_valid = valid_w[gi-1];
        assign prev_key   = key_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign next_valid = 1'b0;
        assign next_key   = '0;
      end else begin : g_mid
        assign next_valid = valid_w[gi+1];
        assign next_key   = key_w[gi+1];
      end
      smpq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_take  (prev_take),
        .prev_valid (prev_valid),
        .prev_key   (prev_key),
        .next_valid (next_valid),
        .next_key   (next_key),
        .take       (take_w[gi]),
        .valid      (valid_w[gi]),
        .key        (key_w[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop && valid_w[0]) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      popped_valid_r <= ctl.pop && valid_w[0];
      was_empty_r    <= ctl.pop && !valid_w[0];
      dropped_r      <= ctl.push && full;
      occ_r          <= count_nxt;
      if (ctl.pop) begin
        key_out_r <= valid_w[0] ? key_w[0] : '1;
      end else begin
        key_out_r <= '0;
      end
    end
  end

  assign out_strobe       = strobe_r;
  assign out_popped_valid = popped_valid_r;
  assign out_key_out      = key_out_r;
  assign out_was_empty    = was_empty_r;
  assign out_dropped      = dropped_r;
  assign out_occupancy    = occ_r;

endmodule

/* tb/tb_sorted_max_priority_queue.sv */
// tb_sorted_max_priority_queue: self-checking bench for the max-first priority queue.
// Drives push/pop beats in random bursts, predicts every result and checks it.
// Depends on smpq_pkg and sorted_max_priority_queue.
module tb_sorted_max_priority_queue;
  import smpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;

  typedef struct {
    logic                 popped_valid;
    key_t                 key_out;
    logic                 was_empty;
    logic                 dropped;
    logic [CNT_W-1:0]     occupancy;
  } pq_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_action = ACT_PUSH;
  key_t               in_key_in = '0;
  logic               out_strobe;
  logic               out_popped_valid;
  key_t               out_key_out;
  logic               out_was_empty;
  logic               out_dropped;
  logic [CNT_W-1:0]   out_occupancy;

  key_t               held_keys [DEPTH];
  int                 held_count = 0;
  pq_result_t         pending_results [$];
  pq_result_t         want;
  int                 err_count = 0;
  int                 beats_sent = 0;
  int                 empty_pops = 0;
  int                 drop_count = 0;
  int                 full_hits = 0;
  int                 stall_cycles = 0;

  sorted_max_priority_queue uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_key_in        (in_key_in),
    .out_strobe       (out_strobe),
    .out_popped_valid (out_popped_valid),
    .out_key_out      (out_key_out),
    .out_was_empty    (out_was_empty),
    .out_dropped      (out_dropped),
    .out_occupancy    (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sorted-store model: descending keys, new key goes after equal ones
  function automatic pq_result_t pq_apply(input logic act, input key_t key);
    pq_result_t r;
    int pos;
    r.popped_valid = 1'b0;
    r.key_out      = '0;
    r.was_empty    = 1'b0;
    r.dropped      = 1'b0;
    if (act == ACT_POP) begin
      if (held_count == 0) begin
        r.was_empty = 1'b1;
        r.key_out   = -1;
        empty_pops++;
      end else begin
        r.popped_valid = 1'b1;
        r.key_out      = held_keys[0];
        for (int i = 0; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
        held_count--;
      end
    end else begin
      pos = 0;
      while (pos < held_count && !(key > held_keys[pos])) pos++;
      if (held_count >= DEPTH) begin
        r.dropped = 1'b1;
        drop_count++;
        if (pos < DEPTH) begin
          for (int i = DEPTH - 1; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = key;
        end
      end else begin
        for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
        held_keys[pos] = key;
        held_count++;
        if (held_count == DEPTH) full_hits++;
      end
    end
    r.occupancy = held_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3, 4, 5: return $signed($urandom_range(0, 8)) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  // holds start high; caller decides whether the next beat follows at once
  task automatic send_beat(input logic act, input key_t key);
    start     <= 1'b1;
    in_action <= act;
    in_key_in <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(pq_apply(act, key));
    beats_sent++;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start     <= 1'b0;
      in_action <= 1'($urandom_range(0, 1));
      in_key_in <= $signed($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int push_pct, input bit with_gaps);
    int left;
    int burst;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) begin
        send_beat(($urandom_range(1, 100) <= push_pct) ? ACT_PUSH : ACT_POP, pick_key());
      end
      left -= burst;
      if (with_gaps && $urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
    end
  endtask

  task automatic test_empty_pops();
    send_beat(ACT_POP, 32'sh7fffffff);
    send_beat(ACT_POP, 32'sh80000000);
  endtask

  task automatic test_key_extremes();
    send_beat(ACT_PUSH, 32'sh80000000);
    send_beat(ACT_PUSH, 32'sh7fffffff);
    idle_for(2);
    send_beat(ACT_PUSH, 32'sd0);
    send_beat(ACT_PUSH, -32'sd1);
    send_beat(ACT_PUSH, -32'sd1);
    idle_for(1);
    repeat (6) send_beat(ACT_POP, $signed($urandom));
  endtask

  task automatic test_fill_and_overflow();
    run_phase(300, 85, 1'b1);
  endtask

  task automatic test_drain_to_empty();
    run_phase(150, 25, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    run_phase(300, 50, 1'b1);
  endtask

  task automatic test_back_to_back();
    run_phase(285, 70, 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, actual key %0h occupancy %0d",
                 $time, out_key_out, out_occupancy);
      end else begin
        want = pending_results.pop_front();
        check_field("popped_valid", 32'(want.popped_valid), 32'(out_popped_valid));
        check_field("key_out", want.key_out, out_key_out);
        check_field("was_empty", 32'(want.was_empty), 32'(out_was_empty));
        check_field("dropped", 32'(want.dropped), 32'(out_dropped));
        check_field("occupancy", 32'(want.occupancy), 32'(out_occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pops();
    test_key_extremes();
    test_fill_and_overflow();
    test_drain_to_empty();
    test_pause_until_drained();
    test_back_to_back();
    wait_drained();
    repeat (4) @(posedge clk);
    $display("summary: %0d beats, %0d pops of an empty queue, %0d pushes into a full queue,",
             beats_sent, empty_pops, drop_count);
    $display("summary: queue filled to depth %0d times", full_hits);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/smpq_pkg.sv
hdl/smpq_cell.sv
hdl/sorted_max_priority_queue.sv
tb/tb_sorted_max_priority_queue.sv
